// ===== rtl/locd_pkg.sv =====
// locd_pkg: shared sizes, types and command/status structs for the
// lock-order cycle detector. No dependencies.
package locd_pkg;

    // sizing
    localparam int unsigned MAX_LOCKS   = 16;
    localparam int unsigned MAX_THREADS = 4;
    localparam int unsigned LOCK_W      = $clog2(MAX_LOCKS);
    localparam int unsigned THREAD_W    = $clog2(MAX_THREADS);

    typedef logic [LOCK_W-1:0]    t_lock_id;
    typedef logic [THREAD_W-1:0]  t_thread_id;
    typedef logic [MAX_LOCKS-1:0] t_lock_mask;

    // operation codes
    typedef enum logic {
        OP_ACQUIRE = 1'b0,
        OP_RELEASE = 1'b1
    } t_op;

    localparam t_lock_id LAST_PIVOT = t_lock_id'(MAX_LOCKS - 1);

    // controller to datapath
    typedef struct packed {
        logic     accept;
        logic     close_step;
        t_lock_id pivot;
        logic     load_result;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic new_edge;
        logic out_ready;
    } t_dp_status;

endpackage

// ===== rtl/locd_dp.sv =====
// locd_dp: order matrix, per-thread held sets, closure row update and
// result output register. Depends on locd_pkg.
module locd_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  locd_pkg::t_dp_cmd     i_cmd,
    output locd_pkg::t_dp_status  o_status,
    input  logic                  i_operation,
    input  locd_pkg::t_thread_id  i_thread_id,
    input  locd_pkg::t_lock_id    i_lock_id,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic                  o_report_valid,
    output logic                  o_cycle_found,
    output locd_pkg::t_lock_mask  o_cycle_mask
);
    import locd_pkg::*;

    t_lock_mask r_order [MAX_LOCKS];
    t_lock_mask n_order [MAX_LOCKS];
    t_lock_mask r_held  [MAX_THREADS];
    t_lock_mask n_held  [MAX_THREADS];
    logic       r_report;
    logic       n_report;

    logic       r_out_valid;
    logic       r_out_report;
    t_lock_mask r_out_mask;

    t_lock_mask held_sel;
    t_lock_mask lock_bit;
    t_lock_mask lock_col;
    t_lock_mask new_edges;
    t_lock_mask pivot_row;
    t_lock_mask diag;
    t_lock_mask result_mask;
    logic       is_acquire;

    // edges that an acquire would add: held locks not yet ordered before it
    always_comb begin
        held_sel   = r_held[i_thread_id];
        lock_bit   = t_lock_mask'(1) << i_lock_id;
        is_acquire = (i_operation == OP_ACQUIRE);
        for (int u = 0; u < MAX_LOCKS; u++) begin
            lock_col[u] = r_order[u][i_lock_id];
        end
        new_edges = held_sel & ~lock_col;
    end

    assign o_status.new_edge  = is_acquire && (|new_edges);
    assign o_status.out_ready = !r_out_valid || !i_out_stall;

    // next matrix and held sets: item update or one closure pivot
    always_comb begin
        n_order   = r_order;
        n_held    = r_held;
        n_report  = r_report;
        pivot_row = r_order[i_cmd.pivot];
        if (i_cmd.accept) begin
            if (is_acquire) begin
                for (int u = 0; u < MAX_LOCKS; u++) begin
                    if (new_edges[u]) begin
                        n_order[u] = r_order[u] | lock_bit;
                    end
                end
                n_held[i_thread_id] = held_sel | lock_bit;
                n_report            = |new_edges;
            end else begin
                n_held[i_thread_id] = held_sel & ~lock_bit;
                n_report            = 1'b0;
            end
        end else if (i_cmd.close_step) begin
            // every row that reaches the pivot inherits the pivot's row
            for (int i = 0; i < MAX_LOCKS; i++) begin
                if (r_order[i][i_cmd.pivot]) begin
                    n_order[i] = r_order[i] | pivot_row;
                end
            end
        end
    end

    // matrix and held set registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_LOCKS; i++) begin
                r_order[i] <= '0;
            end
            for (int t = 0; t < MAX_THREADS; t++) begin
                r_held[t] <= '0;
            end
            r_report <= 1'b0;
        end else begin
            r_order  <= n_order;
            r_held   <= n_held;
            r_report <= n_report;
        end
    end

    // locks that reach themselves, reported only after a recheck
    always_comb begin
        for (int i = 0; i < MAX_LOCKS; i++) begin
            diag[i] = r_order[i][i];
        end
        result_mask = r_report ? diag : '0;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_result) begin
            r_out_report <= r_report;
            r_out_mask   <= result_mask;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_report_valid = r_out_report;
    assign o_cycle_mask   = r_out_mask;
    assign o_cycle_found  = |r_out_mask;

endmodule

// ===== rtl/locd_ctrl.sv =====
// locd_ctrl: controller state machine that sequences accept, closure
// pivots and result load. Depends on locd_pkg.
module locd_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  locd_pkg::t_dp_status  i_status,
    output locd_pkg::t_dp_cmd     o_cmd
);
    import locd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CLOSE,
        S_FINISH
    } t_state;

    t_state   r_state;
    t_lock_id r_pivot;
    logic     r_stall;

    // commands to the datapath
    always_comb begin
        o_cmd.accept      = (r_state == S_IDLE) && i_in_valid;
        o_cmd.close_step  = (r_state == S_CLOSE);
        o_cmd.pivot       = r_pivot;
        o_cmd.load_result = (r_state == S_FINISH) && i_status.out_ready;
    end

    assign o_in_stall = r_stall;

    // state, pivot counter and stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pivot <= '0;
            r_stall <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_pivot <= '0;
                        r_stall <= 1'b1;
                        r_state <= i_status.new_edge ? S_CLOSE : S_FINISH;
                    end
                end
                S_CLOSE: begin
                    if (r_pivot == LAST_PIVOT) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_pivot <= r_pivot + t_lock_id'(1);
                    end
                end
                S_FINISH: begin
                    if (i_status.out_ready) begin
                        r_stall <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/lock_order_cycle_detector_unit.sv =====
// lock_order_cycle_detector_unit: top level joining controller and datapath.
// Depends on locd_pkg, locd_ctrl and locd_dp.
//
// Input channel (i_in_valid / o_in_stall) carries one transaction per lock
// acquire or release: operation, thread id and lock id. Output channel
// (o_out_valid / i_out_stall) returns exactly one result transaction per
// input: report flag, cycle flag and the per-lock cycle mask.
// An acquire that adds a new ordering edge updates the matrix in the accept
// cycle, then runs the transitive closure one pivot per cycle, each over all
// rows, through all MAX_LOCKS pivots, and loads the result register in the
// finish state once the output register can take it; the next input can
// be taken in the cycle after that load. Releases and acquires that add no
// edge skip the closure and go from accept straight to the finish state.
// The closure pivot loop makes edge-adding acquires the long case.
// One transaction is worked on at a time; the input is stalled from accept
// until its result is loaded. A result waiting in the output register does
// not block a new accept, but a finished result waits while the receiver
// stalls and the output register is still full.
// Synchronous reset clears the order matrix, the held sets and all
// control state; the block accepts transactions in the first cycle after.
module lock_order_cycle_detector_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_operation,
    input  locd_pkg::t_thread_id  i_thread_id,
    input  locd_pkg::t_lock_id    i_lock_id,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_report_valid,
    output logic                  o_cycle_found,
    output locd_pkg::t_lock_mask  o_cycle_mask
);
    import locd_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    // controller
    locd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath
    locd_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_operation    (i_operation),
        .i_thread_id    (i_thread_id),
        .i_lock_id      (i_lock_id),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_report_valid (o_report_valid),
        .o_cycle_found  (o_cycle_found),
        .o_cycle_mask   (o_cycle_mask)
    );

    // busy after every accepted transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accept");

    // a cycle can only be reported by a recheck
    a_cycle_needs_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_cycle_found) |-> o_report_valid)
        else $error("cycle flagged without recheck");

    // no recheck means an empty mask
    a_mask_needs_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_report_valid) |-> (o_cycle_mask == '0))
        else $error("cycle mask set without recheck");

    // closure never runs while the output side is loaded from it
    a_no_load_during_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.close_step && cmd.load_result))
        else $error("result loaded during closure");

endmodule
